/* sv/wvm_pkg.sv */
`default_nettype none
package wvm_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OpSample = 2'd0;
  localparam logic [1:0] OpWave   = 2'd1;
  localparam logic [1:0] OpRatio  = 2'd2;
  localparam logic [1:0] OpVoice  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] RegWaveA  = 2'd0;
  localparam logic [1:0] RegWaveB  = 2'd1;
  localparam logic [1:0] RegBlendA = 2'd2;
  localparam logic [1:0] RegBlendB = 2'd3;

  localparam int TableLen  = 256;
  localparam int NumTables = 4;
  localparam int NoteCount = 128;
  localparam int VoiceIdxW = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  table_id;
    logic [7:0]  entry_index;
    logic [15:0] entry_value;
    logic [6:0]  ratio_note;
    logic [15:0] rate_num;
    logic [15:0] rate_den;
    logic [3:0]  voice_index;
    logic [6:0]  voice_note;
    logic [7:0]  voice_gain;
    logic        voice_on;
  } item_t;

  typedef struct packed {
    logic [1:0] wave_a;
    logic [1:0] wave_b;
    logic [8:0] blend_a;
    logic [8:0] blend_b;
  } cfg_t;

  typedef struct packed {
    logic                 accept;
    logic                 acc_clear;
    logic                 ratio_rd;
    logic                 mul;
    logic                 div_start;
    logic                 avg_mul;
    logic                 avg_add;
    logic                 wave_rd;
    logic                 blend;
    logic                 gain;
    logic                 acc;
    logic                 out_load;
    logic [VoiceIdxW-1:0] voice;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_WAVE,
    S_BLEND,
    S_GAIN,
    S_ACC,
    S_FINGO,
    S_FIN,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

/* sv/wvm_in_if.sv */
`default_nettype none
interface wvm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  table_id;
  logic [7:0]  entry_index;
  logic [15:0] entry_value;
  logic [6:0]  ratio_note;
  logic [15:0] rate_num;
  logic [15:0] rate_den;
  logic [3:0]  voice_index;
  logic [6:0]  voice_note;
  logic [7:0]  voice_gain;
  logic        voice_on;

  modport source (
    output valid, operation, table_id, entry_index, entry_value, ratio_note,
           rate_num, rate_den, voice_index, voice_note,
           voice_gain, voice_on,
    input  ready
  );
  modport sink (
    input  valid, operation, table_id, entry_index, entry_value, ratio_note,
           rate_num, rate_den, voice_index, voice_note,
           voice_gain, voice_on,
    output ready
  );
endinterface
`default_nettype wire

/* sv/wvm_out_if.sv */
`default_nettype none
interface wvm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface
`default_nettype wire

/* sv/wvm_div.sv */
`default_nettype none
module wvm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  import wvm_pkg::*;

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic [32:0] trial;
  logic [32:0] diff;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial = {rem, quotient[31]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  // Payload registers of the shared divider.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 32'd0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= diff[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= trial[31:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == 5'd31) |=> !busy)
    else $error("divider ran past its last step");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(start)) |-> $past(cnt) == 5'd31)
    else $error("divider stopped early");
`endif

endmodule
`default_nettype wire

/* sv/wvm_ctrl.sv */
`default_nettype none
module wvm_ctrl #(
  parameter int VOICES = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_operation,
  output logic                  in_ready,
  input  wire wvm_pkg::status_t status,
  output wvm_pkg::cmd_t         cmd
);
  import wvm_pkg::*;

  localparam logic [VoiceIdxW-1:0] LastVoice = VoiceIdxW'(VOICES - 1);

  state_t               state, state_next;
  logic [VoiceIdxW-1:0] voice, voice_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      voice <= '0;
    end else begin
      state <= state_next;
      voice <= voice_next;
    end
  end

  // Sequencer: per voice fetch ratio, multiply, divide, read tables, blend, gain, sum.
  always_comb begin
    state_next = state;
    voice_next = voice;
    cmd        = '0;
    cmd.voice  = voice;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_operation == OpSample) begin
          cmd.acc_clear = 1'b1;
          voice_next    = '0;
          state_next    = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd.ratio_rd = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_WAVE;
        end
      end
      S_WAVE: begin
        cmd.wave_rd = 1'b1;
        state_next  = S_BLEND;
      end
      S_BLEND: begin
        cmd.blend  = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (voice == LastVoice) begin
          state_next = S_FINGO;
        end else begin
          voice_next = voice + 1'b1;
          state_next = S_SLOT;
        end
      end
      // Voice average: reciprocal partial products, then their sum.
      S_FINGO: begin
        cmd.avg_mul = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        cmd.avg_add = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a waiting beat");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");
  a_div_wave: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !status.div_busy) |=> state == S_WAVE)
    else $error("voice step skipped the table read");
  a_voice_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> voice <= LastVoice)
    else $error("voice counter out of range");
`endif

endmodule
`default_nettype wire

/* sv/wvm_dp.sv */
`default_nettype none
module wvm_dp #(
  parameter int VOICES      = 10,
  parameter int GAIN_BITS   = 8,
  parameter int BLEND_BITS  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wvm_pkg::item_t item,
  input  wire wvm_pkg::cfg_t  cfg,
  input  wire wvm_pkg::cmd_t  cmd,
  output wvm_pkg::status_t    status,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic [7:0]          sample_out
);
  import wvm_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int Shift = GAIN_BITS + BLEND_BITS;
  localparam logic [7:0] GainMask =
    (GAIN_BITS >= 8) ? 8'hFF : 8'((1 << GAIN_BITS) - 1);
  localparam logic [15:0] SampleMask = 16'((1 << SAMPLE_BITS) - 1);
  // Reciprocal of the voice count, exact for every 32-bit sum.
  localparam int AvgShift = 32 + $clog2(VOICES);
  localparam logic [32:0] AvgMagic =
    33'((64'd1 << AvgShift) / 64'(VOICES) + 64'd1);

  logic [6:0]  slot_note [VOICES];
  logic [7:0]  slot_gain [VOICES];
  logic        slot_on   [VOICES];
  logic [31:0] ratio_mem [NoteCount];
  logic [15:0] wave_mem  [NumTables * TableLen];

  logic [31:0] sample_time;
  logic [31:0] ratio_q;
  logic [31:0] prod;
  logic [15:0] den;
  logic [15:0] wave_a_q;
  logic [15:0] wave_b_q;
  logic [24:0] prod_a;
  logic [24:0] prod_b;
  logic [31:0] voice_val;
  logic [31:0] acc;
  logic [48:0] avg_lo;
  logic [48:0] avg_hi;
  logic [7:0]  avg_q;

  logic [VW-1:0] vsel;
  logic [6:0]    cur_note;
  logic [7:0]    cur_gain;
  logic          cur_on;
  logic          wr_wave;
  logic          wr_ratio;
  logic          wr_voice;
  logic [47:0]   time_prod;
  logic [25:0]   blend_sum;
  logic [33:0]   gain_prod;
  logic [64:0]   avg_sum;
  logic [31:0]   div_dividend;
  logic [31:0]   div_divisor;
  logic          div_busy;
  logic [31:0]   quotient;

  assign vsel     = cmd.voice[VW-1:0];
  assign cur_note = slot_note[vsel];
  assign cur_gain = slot_gain[vsel];
  assign cur_on   = slot_on[vsel];

  assign wr_wave  = cmd.accept && item.operation == OpWave;
  assign wr_ratio = cmd.accept && item.operation == OpRatio;
  assign wr_voice = cmd.accept && item.operation == OpVoice &&
                    item.voice_index < VoiceIdxW'(VOICES);

  // Voice slots; only the sounding flag needs a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        slot_on[i] <= 1'b0;
      end
    end else if (wr_voice) begin
      slot_on[item.voice_index[VW-1:0]] <= item.voice_on;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_voice) begin
      slot_note[item.voice_index[VW-1:0]] <= item.voice_note;
      slot_gain[item.voice_index[VW-1:0]] <= item.voice_gain & GainMask;
    end
  end

  // Per-note ratio memory, numerator in the upper half.
  always_ff @(posedge clk) begin
    if (wr_ratio) begin
      ratio_mem[item.ratio_note] <= {item.rate_num, item.rate_den};
    end
    if (cmd.ratio_rd) begin
      ratio_q <= ratio_mem[cur_note];
    end
  end

  // Waveform memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_wave) begin
      wave_mem[{item.table_id, item.entry_index}] <= item.entry_value & SampleMask;
    end
    if (cmd.wave_rd) begin
      wave_a_q <= wave_mem[{cfg.wave_a, quotient[7:0]}];
      wave_b_q <= wave_mem[{cfg.wave_b, quotient[7:0]}];
    end
  end

  // Phase numerator: sample time times the note's numerator, kept to 32 bits.
  assign time_prod = {16'd0, sample_time} * {32'd0, ratio_q[31:16]};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= time_prod[31:0];
      den  <= ratio_q[15:0];
    end
  end

  // Phase divider: one division per voice.
  assign div_dividend = prod;
  assign div_divisor  = {16'd0, den};

  wvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Blend the two table entries, then scale by the voice gain.
  assign blend_sum = {1'b0, prod_a} + {1'b0, prod_b};
  assign gain_prod = {8'd0, blend_sum} * {26'd0, cur_gain};

  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      prod_a <= {9'd0, wave_a_q} * {16'd0, cfg.blend_a};
      prod_b <= {9'd0, wave_b_q} * {16'd0, cfg.blend_b};
    end
    if (cmd.gain) begin
      voice_val <= gain_prod[31:0];
    end
  end

  // Voice sum; silent voices and zero denominators add nothing.
  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc <= 32'd0;
    end else if (cmd.acc && cur_on && den != 16'd0) begin
      acc <= acc + (voice_val >> Shift);
    end
  end

  // Voice average by reciprocal multiplication, split into two 16-bit halves.
  assign avg_sum = {avg_hi, 16'd0} + {16'd0, avg_lo};

  always_ff @(posedge clk) begin
    if (cmd.avg_mul) begin
      avg_lo <= {33'd0, acc[15:0]} * {16'd0, AvgMagic};
      avg_hi <= {33'd0, acc[31:16]} * {16'd0, AvgMagic};
    end
    if (cmd.avg_add) begin
      avg_q <= avg_sum[AvgShift + 8 +: 8];
    end
  end

  // Output register and sample counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      sample_time <= 32'd0;
    end else if (cmd.out_load) begin
      out_valid   <= 1'b1;
      sample_time <= sample_time + 32'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out <= avg_q;
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || out_ready;

`ifndef NO_ASSERTIONS
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> sample_time == $past(sample_time) + 32'd1)
    else $error("sample counter did not advance");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not shown");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(sample_out))
    else $error("waiting result changed");
`endif

endmodule
`default_nettype wire

/* sv/wavetable_voice_mixer.sv */
`default_nettype none
// Write beats (wave entry, ratio, voice) are taken one per cycle while idle.
// A sample beat shows its result once every voice is mixed and the sum is averaged;
// each voice runs the 32-step restoring phase divider plus its fetch and math steps.
// The input reopens in the cycle after the result is loaded, so a new sample waits
// for the last; a result still waiting holds the next sample in its last state.
// Reset clears the sample counter, turns all voices off and loads register defaults.
module wavetable_voice_mixer #(
  parameter int VOICES      = 10,
  parameter int GAIN_BITS   = 8,
  parameter int BLEND_BITS  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  wvm_in_if.sink           item,
  wvm_out_if.source        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import wvm_pkg::*;

  cfg_t    cfg;
  item_t   item_beat;
  cmd_t    cmd;
  status_t status;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_a  <= 2'd0;
      cfg.wave_b  <= 2'd0;
      cfg.blend_a <= 9'd256;
      cfg.blend_b <= 9'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegWaveA:  cfg.wave_a  <= pwdata[1:0];
        RegWaveB:  cfg.wave_b  <= pwdata[1:0];
        RegBlendA: cfg.blend_a <= pwdata[8:0];
        RegBlendB: cfg.blend_b <= pwdata[8:0];
        default:   ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[3:2])
      RegWaveA:  prdata = {30'd0, cfg.wave_a};
      RegWaveB:  prdata = {30'd0, cfg.wave_b};
      RegBlendA: prdata = {23'd0, cfg.blend_a};
      RegBlendB: prdata = {23'd0, cfg.blend_b};
      default:   prdata = 32'd0;
    endcase
  end

  // Gather the input beat into one word for the datapath.
  assign item_beat.operation   = item.operation;
  assign item_beat.table_id    = item.table_id;
  assign item_beat.entry_index = item.entry_index;
  assign item_beat.entry_value = item.entry_value;
  assign item_beat.ratio_note  = item.ratio_note;
  assign item_beat.rate_num    = item.rate_num;
  assign item_beat.rate_den    = item.rate_den;
  assign item_beat.voice_index = item.voice_index;
  assign item_beat.voice_note  = item.voice_note;
  assign item_beat.voice_gain  = item.voice_gain;
  assign item_beat.voice_on    = item.voice_on;

  wvm_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (item.valid),
    .in_operation (item.operation),
    .in_ready     (item.ready),
    .status       (status),
    .cmd          (cmd)
  );

  wvm_dp #(
    .VOICES      (VOICES),
    .GAIN_BITS   (GAIN_BITS),
    .BLEND_BITS  (BLEND_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (item_beat),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .sample_out (result.sample_out)
  );

endmodule
`default_nettype wire

/* bench/tb_wavetable_voice_mixer.sv */
`default_nettype none
module tb_wavetable_voice_mixer;
  import wvm_pkg::*;

  localparam int NumVoices  = 10;
  localparam int DrainWait  = 450;
  localparam int LongHold   = 3000;
  localparam int RandItems  = 498;
  localparam int ChunkCount = 6;
  localparam int FillLen    = 128;
  localparam int NoteSet    = 16;
  localparam int ItemW      = $bits(item_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wvm_in_if  in_bus ();
  wvm_out_if out_bus ();

  wavetable_voice_mixer uut (
    .clk(clk), .rst(rst), .item(in_bus), .result(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Beats waiting to be offered and samples waiting to come out.
  item_t      pending_q[$];
  logic [7:0] sample_q[$];
  int         errors = 0;
  int         idle_mode = 0;
  bit         hold_armed = 1'b0;
  bit         hold_done = 1'b0;
  int         hold_count = 0;
  bit         taken = 1'b0;

  // Shadow of the mixer state.
  logic [15:0] wave_mem [NumTables*TableLen];
  logic [15:0] num_mem [NoteCount];
  logic [15:0] den_mem [NoteCount];
  logic [6:0]  slot_note [NumVoices];
  logic [7:0]  slot_gain [NumVoices];
  logic        slot_on [NumVoices];
  logic [31:0] sample_time = '0;
  cfg_t        cfg = '{wave_a: 2'd0, wave_b: 2'd0, blend_a: 9'd256, blend_b: 9'd0};

  initial begin
    for (int v = 0; v < NumVoices; v++) begin
      slot_note[v] = '0;
      slot_gain[v] = '0;
      slot_on[v] = 1'b0;
    end
  end

  // Contribution of one sounding voice at the current sample time.
  function automatic logic [31:0] voice_level(int v);
    logic [15:0] num, den;
    logic [31:0] prod, phase, e1, e2, acc;
    num = num_mem[slot_note[v]];
    den = den_mem[slot_note[v]];
    if (den == 16'd0) return 32'd0;
    prod = sample_time * {16'd0, num};
    phase = (prod / {16'd0, den}) & 32'hFF;
    e1 = {16'd0, wave_mem[{cfg.wave_a, phase[7:0]}]};
    e2 = {16'd0, wave_mem[{cfg.wave_b, phase[7:0]}]};
    acc = e1 * {23'd0, cfg.blend_a} + e2 * {23'd0, cfg.blend_b};
    acc = acc * {24'd0, slot_gain[v]};
    return acc >> 16;
  endfunction

  // Applies one accepted beat to the shadow state and queues any sample it makes.
  task automatic mix_predict(input item_t it);
    logic [31:0] sum;
    sum = '0;
    case (it.operation)
      OpWave: wave_mem[{it.table_id, it.entry_index}] = it.entry_value;
      OpRatio: begin
        num_mem[it.ratio_note] = it.rate_num;
        den_mem[it.ratio_note] = it.rate_den;
      end
      OpVoice: begin
        if (it.voice_index < NumVoices) begin
          slot_note[it.voice_index] = it.voice_note;
          slot_gain[it.voice_index] = it.voice_gain;
          slot_on[it.voice_index] = it.voice_on;
        end
      end
      default: begin
        for (int v = 0; v < NumVoices; v++)
          if (slot_on[v]) sum = sum + voice_level(v);
        sum = sum / NumVoices;
        sample_q.push_back(sum[15:8]);
        sample_time = sample_time + 32'd1;
      end
    endcase
  endtask

  // Accept side: a beat moves when valid and ready are both high.
  always @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      mix_predict(pending_q.pop_front());
      taken = 1'b1;
    end
  end

  // Driver: offers the head of the pending queue, with random gaps between beats.
  always @(negedge clk) begin
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 16 : (idle_mode == 1) ? 61 : 0;
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || taken) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
        in_bus.valid <= 1'b1;
        {in_bus.operation, in_bus.table_id, in_bus.entry_index, in_bus.entry_value,
         in_bus.ratio_note, in_bus.rate_num, in_bus.rate_den,
         in_bus.voice_index, in_bus.voice_note, in_bus.voice_gain,
         in_bus.voice_on} <= pending_q[0];
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    taken = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == 0) ? 61 : (idle_mode == 1) ? 16 : 0;
    if (hold_armed && !hold_done && sample_q.size() > 0) begin
      hold_done = 1'b1;
      hold_count = LongHold;
    end
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count = hold_count - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: each sample beat is checked against the oldest prediction.
  always @(posedge clk) begin
    logic [7:0] want;
    if (out_bus.valid && out_bus.ready) begin
      if (sample_q.size() == 0) begin
        $error("sample_out: unexpected beat, actual %0d", out_bus.sample_out);
        errors++;
      end else begin
        want = sample_q.pop_front();
        if (out_bus.sample_out !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, out_bus.sample_out);
          errors++;
        end
      end
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegWaveA: cfg.wave_a = data[1:0];
      RegWaveB: cfg.wave_b = data[1:0];
      RegBlendA: cfg.blend_a = data[8:0];
      default: cfg.blend_b = data[8:0];
    endcase
  endtask

  task automatic set_mix(input logic [1:0] wa, input logic [1:0] wb,
                         input logic [8:0] ba, input logic [8:0] bb);
    reg_write(RegWaveA, {$urandom} & ~32'h3 | wa);
    reg_write(RegWaveB, {$urandom} & ~32'h3 | wb);
    reg_write(RegBlendA, {$urandom} & ~32'h1FF | ba);
    reg_write(RegBlendB, {$urandom} & ~32'h1FF | bb);
  endtask

  // Waits until the block has drained everything offered so far.
  task automatic drain;
    wait (pending_q.size() == 0 && sample_q.size() == 0);
    repeat (DrainWait) @(negedge clk);
  endtask

  function automatic item_t fill_fields();
    item_t it;
    it = ItemW'({$urandom, $urandom, $urandom});
    return it;
  endfunction

  // Random beat; notes stay in the written set and ratios at or below one quarter.
  function automatic item_t rand_beat();
    item_t it;
    int pick;
    it = fill_fields();
    pick = $urandom_range(99);
    if (pick < 35) it.operation = OpSample;
    else if (pick < 60) it.operation = OpVoice;
    else if (pick < 80) it.operation = OpRatio;
    else it.operation = OpWave;
    if (it.operation == OpVoice) begin
      if ($urandom_range(9) < 8) it.voice_index = 4'($urandom_range(NumVoices - 1));
      it.voice_note = 7'($urandom_range(NoteSet - 1));
      it.voice_on = ($urandom_range(9) < 7);
    end
    if (it.operation == OpRatio) begin
      it.ratio_note = 7'($urandom_range(NoteSet - 1));
      if ($urandom_range(9) == 0) it.rate_den = '0;
      it.rate_num = 16'($urandom_range(32'(it.rate_den) / 4, 0));
    end
    return it;
  endfunction

  function automatic item_t mk_ratio(logic [6:0] n, logic [15:0] num, logic [15:0] den);
    item_t it;
    it = fill_fields();
    it.operation = OpRatio;
    it.ratio_note = n;
    it.rate_num = num;
    it.rate_den = den;
    return it;
  endfunction

  function automatic item_t mk_voice(logic [3:0] v, logic [6:0] n, logic [7:0] g, logic on);
    item_t it;
    it = fill_fields();
    it.operation = OpVoice;
    it.voice_index = v;
    it.voice_note = n;
    it.voice_gain = g;
    it.voice_on = on;
    return it;
  endfunction

  function automatic item_t mk_sample();
    item_t it;
    it = fill_fields();
    it.operation = OpSample;
    return it;
  endfunction

  initial begin
    item_t it;
    int    num_v;
    int    den_v;
    in_bus.valid = 1'b0;
    {in_bus.operation, in_bus.table_id, in_bus.entry_index, in_bus.entry_value,
     in_bus.ratio_note, in_bus.rate_num, in_bus.rate_den,
     in_bus.voice_index, in_bus.voice_note, in_bus.voice_gain, in_bus.voice_on} = '0;
    out_bus.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the low half of every wave table and the ratios of the notes in use.
    // With fewer than 512 samples and every ratio at most one quarter, the phase
    // stays below 128, so no read ever hits an unwritten entry.
    for (int i = 0; i < NumTables*FillLen; i++) begin
      it = fill_fields();
      it.operation = OpWave;
      it.table_id = 2'(i / FillLen);
      it.entry_index = 8'(i % FillLen);
      if (it.entry_index == 8'd0) it.entry_value = 16'hFFFF;
      if (it.entry_index == 8'(FillLen - 1)) it.entry_value = 16'h0000;
      pending_q.push_back(it);
    end
    for (int n = 0; n < NoteSet; n++) begin
      den_v = $urandom_range(65535, 1);
      num_v = $urandom_range(den_v / 4, 0);
      pending_q.push_back(mk_ratio(7'(n), 16'(num_v), 16'(den_v)));
    end

    // Directed: ratio extremes, zero denominator, voice slot edges and ignored slots.
    pending_q.push_back(mk_sample());
    pending_q.push_back(mk_ratio(7'd0, 16'h3FFF, 16'hFFFF));
    pending_q.push_back(mk_ratio(7'd15, 16'd0, 16'hFFFF));
    pending_q.push_back(mk_ratio(7'd5, 16'd300, 16'd0));
    pending_q.push_back(mk_voice(4'd0, 7'd0, 8'hFF, 1'b1));
    pending_q.push_back(mk_sample());
    pending_q.push_back(mk_sample());
    pending_q.push_back(mk_voice(4'd9, 7'd15, 8'hFF, 1'b1));
    pending_q.push_back(mk_voice(4'd3, 7'd5, 8'hFF, 1'b1));
    pending_q.push_back(mk_sample());
    pending_q.push_back(mk_voice(4'd10, 7'd1, 8'hFF, 1'b1));
    pending_q.push_back(mk_voice(4'd15, 7'd2, 8'h80, 1'b1));
    pending_q.push_back(mk_sample());
    for (int v = 1; v < 9; v++)
      if (v != 3) pending_q.push_back(mk_voice(4'(v), 7'd0, 8'hFF, 1'b1));
    pending_q.push_back(mk_sample());
    pending_q.push_back(mk_voice(4'd0, 7'd0, 8'd0, 1'b0));
    pending_q.push_back(mk_sample());
    drain();

    // Wide blend weights make the gained products wrap.
    set_mix(2'd3, 2'd2, 9'd511, 9'd511);
    repeat (3) pending_q.push_back(mk_sample());
    drain();

    // Random beats in chunks: a mix setting per chunk, an idle pattern per pair.
    for (int c = 0; c < ChunkCount; c++) begin
      case (c)
        0: set_mix(2'd0, 2'd1, 9'd256, 9'd0);
        1: set_mix(2'd2, 2'd3, 9'd0, 9'd256);
        2: set_mix(2'd1, 2'd2, 9'd0, 9'd0);
        3: set_mix(2'd3, 2'd0, 9'd128, 9'd128);
        default: set_mix(2'($urandom), 2'($urandom), 9'($urandom), 9'($urandom));
      endcase
      idle_mode = c / 2;
      if (c == 1) hold_armed = 1'b1;
      for (int k = 0; k < RandItems / ChunkCount; k++) pending_q.push_back(rand_beat());
      drain();
    end

    if (errors == 0) begin
      $display("wavetable_voice_mixer: match");
    end else begin
      $display("wavetable_voice_mixer: mismatch");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #6000000;
    $display("wavetable_voice_mixer: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
sv/wvm_pkg.sv
sv/wvm_in_if.sv
sv/wvm_out_if.sv
sv/wvm_div.sv
sv/wvm_ctrl.sv
sv/wvm_dp.sv
sv/wavetable_voice_mixer.sv
bench/tb_wavetable_voice_mixer.sv
